### src/sspg_pkg.sv
// Shared constants, register codes and sine quarter-wave tables of the setpoint generator.
package sspg_pkg;

    // Defaults for the top-level parameters.
    localparam int SINE_SAMPLES_DEF = 100;
    localparam int FRAC_BITS_DEF    = 4;

    // Fixed field widths.
    localparam int SETPOINT_W = 14;
    localparam int TARGET_W   = 11;
    localparam int RPM_W      = 10;
    localparam int STEP_W     = 8;
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int SAMPLE_W   = 16;  // signed scaled sine sample
    localparam int SUM_W      = 20;  // signed setpoint arithmetic before clamping

    localparam int ROM_POINTS   = 100;
    localparam int QUARTER_LEN  = 25;
    localparam int SETPOINT_MAX = 16383;

    // Mode codes.
    localparam logic [MODE_W-1:0] MODE_STEP_UP   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_UP_DOWN   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_STEP_DOWN = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SINE      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PERIODIC  = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_STEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_MIN = 3'd4;

    // Register reset values.
    localparam logic [MODE_W-1:0] MODE_RESET      = MODE_UP_DOWN;
    localparam logic [STEP_W-1:0] UP_STEP_RESET   = 8'd50;
    localparam logic [STEP_W-1:0] DOWN_STEP_RESET = 8'd10;
    localparam logic [RPM_W-1:0]  SWEEP_MAX_RESET = 10'd650;
    localparam logic [RPM_W-1:0]  SWEEP_MIN_RESET = 10'd50;

    // Periodic sine offset sequence, whole rpm.
    localparam logic [RPM_W-1:0] OFFSET_LOW  = 10'd350;
    localparam logic [RPM_W-1:0] OFFSET_HIGH = 10'd575;
    localparam logic [RPM_W-1:0] OFFSET_STEP = 10'd50;
    localparam logic [RPM_W-1:0] SINE_CENTER = 10'd500;

    // Quarter wave of round(16*100*sin(2*pi*k/100)).
    function automatic int quarter_a100(input int k);
        int v;
        case (k)
            0: v = 0;       1: v = 100;     2: v = 201;     3: v = 300;
            4: v = 398;     5: v = 494;     6: v = 589;     7: v = 681;
            8: v = 771;     9: v = 857;     10: v = 940;    11: v = 1020;
            12: v = 1095;   13: v = 1166;   14: v = 1233;   15: v = 1294;
            16: v = 1351;   17: v = 1402;   18: v = 1448;   19: v = 1488;
            20: v = 1522;   21: v = 1550;   22: v = 1572;   23: v = 1587;
            24: v = 1597;   25: v = 1600;
            default: v = 0;
        endcase
        return v;
    endfunction

    // Quarter wave of round(16*50*sin(2*pi*k/100)).
    function automatic int quarter_a50(input int k);
        int v;
        case (k)
            0: v = 0;       1: v = 50;      2: v = 100;     3: v = 150;
            4: v = 199;     5: v = 247;     6: v = 294;     7: v = 341;
            8: v = 385;     9: v = 429;     10: v = 470;    11: v = 510;
            12: v = 548;    13: v = 583;    14: v = 616;    15: v = 647;
            16: v = 675;    17: v = 701;    18: v = 724;    19: v = 744;
            20: v = 761;    21: v = 775;    22: v = 786;    23: v = 794;
            24: v = 798;    25: v = 800;
            default: v = 0;
        endcase
        return v;
    endfunction

endpackage

### src/sspg_in_if.sv
// Tick input channel of the setpoint generator.
interface sspg_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

### src/sspg_out_if.sv
// Setpoint result channel of the setpoint generator.
interface sspg_out_if
    import sspg_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [SETPOINT_W-1:0] setpoint;
    logic                  sweep_done;

    modport source (output valid, output setpoint, output sweep_done, input ready);
    modport sink   (input valid, input setpoint, input sweep_done, output ready);
endinterface

### src/sspg_sine_rom.sv
// Per-phase sine sample table for both amplitudes, built at elaboration.
module sspg_sine_rom
    import sspg_pkg::*;
#(
    parameter int SINE_SAMPLES = SINE_SAMPLES_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    localparam int PHASE_W     = $clog2(SINE_SAMPLES)
) (
    input  logic [PHASE_W-1:0]         phase,
    output logic signed [SAMPLE_W-1:0] sample_a100,
    output logic signed [SAMPLE_W-1:0] sample_a50
);

    localparam int DEPTH = 2 ** PHASE_W;

    logic signed [SAMPLE_W-1:0] rom_a100 [DEPTH];
    logic signed [SAMPLE_W-1:0] rom_a50  [DEPTH];

    // Each phase maps to the 100-point wave, folded from the quarter tables
    // and rescaled to the setpoint fraction; phases past the period read zero.
    for (genvar g = 0; g < DEPTH; g++) begin : g_entry
        localparam int IDX  = (g < SINE_SAMPLES) ? (g * ROM_POINTS) / SINE_SAMPLES : 0;
        localparam int QUAD = IDX / QUARTER_LEN;
        localparam int REM  = IDX % QUARTER_LEN;
        localparam int POS  = (QUAD % 2 == 1) ? QUARTER_LEN - REM : REM;
        localparam int M100 = (quarter_a100(POS) * (2 ** FRAC_BITS) + 8) / 16;
        localparam int M50  = (quarter_a50(POS) * (2 ** FRAC_BITS) + 8) / 16;
        localparam int S100 = (g >= SINE_SAMPLES) ? 0 : ((QUAD >= 2) ? -M100 : M100);
        localparam int S50  = (g >= SINE_SAMPLES) ? 0 : ((QUAD >= 2) ? -M50 : M50);

        assign rom_a100[g] = SAMPLE_W'(S100);
        assign rom_a50[g]  = SAMPLE_W'(S50);
    end

    assign sample_a100 = rom_a100[phase];
    assign sample_a50  = rom_a50[phase];

endmodule

### src/speed_setpoint_profile_generator.sv
// Top level of the motor speed setpoint profile generator.

// Each input transfer is one control tick and produces exactly one result transfer carrying a
// speed setpoint in units of 1/2^FRAC_BITS rpm and a sweep-done flag. The block accepts one tick
// per clock cycle while its output is not stalled: the profile state is updated at the input
// transfer by a short combinational pass (sine table lookup, one add and a clamp, or a sweep step
// and compare), and the result is registered in the output register. The input is ready whenever
// that output register is empty or is being drained in the same cycle, so a full rate stream
// runs without gaps. Modes are step-up sweep, up-and-down sweep, step-down sweep, a sine around
// 500 rpm and a periodic sine whose offset steps through 350 to 550 rpm. A tick with restart set
// reloads the sweep and sine state before it is handled. Configuration registers are written
// through the plain write port and should only change while no tick is in flight.
module speed_setpoint_profile_generator
    import sspg_pkg::*;
#(
    parameter int SINE_SAMPLES = SINE_SAMPLES_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    sspg_in_if.sink               in_ch,
    sspg_out_if.source            out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PHASE_W = $clog2(SINE_SAMPLES);
    localparam int STRIDE  = (SINE_SAMPLES * 40) / 1000;
    localparam logic [PHASE_W:0] PHASE_END = (PHASE_W + 1)'(SINE_SAMPLES);
    localparam logic [PHASE_W:0] PHASE_INC = (PHASE_W + 1)'(STRIDE);

    // Configuration registers.
    logic [MODE_W-1:0] mode_reg;
    logic [STEP_W-1:0] up_step_reg;
    logic [STEP_W-1:0] down_step_reg;
    logic [RPM_W-1:0]  sweep_max_reg;
    logic [RPM_W-1:0]  sweep_min_reg;

    // Profile state.
    logic [TARGET_W-1:0] step_target_reg, step_target_next;
    logic                second_tick_reg, second_tick_next;
    logic                finished_reg, finished_next;
    logic                primed_reg, primed_next;
    logic [PHASE_W-1:0]  sine_phase_reg, sine_phase_next;
    logic [RPM_W-1:0]    sine_offset_reg, sine_offset_next;

    // Output register.
    logic                  out_valid_reg;
    logic [SETPOINT_W-1:0] setpoint_reg, setpoint_next;
    logic                  done_reg, done_next;

    // State after an optional restart, before this tick is handled.
    logic [TARGET_W-1:0] target_base;
    logic                second_base;
    logic                finished_base;
    logic                primed_base;
    logic [PHASE_W-1:0]  phase_base;
    logic [RPM_W-1:0]    offset_base;

    logic [TARGET_W-1:0] target_loaded;
    logic [TARGET_W-1:0] rpm;
    logic [SUM_W-1:0]    rpm_scaled;
    logic signed [SUM_W-1:0] sine_sum;
    logic [PHASE_W:0]    phase_stride;
    logic [PHASE_W:0]    phase_inc;
    logic [RPM_W-1:0]    offset_stepped;

    logic signed [SAMPLE_W-1:0] sample_a100;
    logic signed [SAMPLE_W-1:0] sample_a50;

    logic tick_xfer;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign tick_xfer   = in_ch.valid && in_ch.ready;

    sspg_sine_rom #(
        .SINE_SAMPLES (SINE_SAMPLES),
        .FRAC_BITS    (FRAC_BITS)
    ) u_sine_rom (
        .phase       (phase_base),
        .sample_a100 (sample_a100),
        .sample_a50  (sample_a50)
    );

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_RESET;
            up_step_reg   <= UP_STEP_RESET;
            down_step_reg <= DOWN_STEP_RESET;
            sweep_max_reg <= SWEEP_MAX_RESET;
            sweep_min_reg <= SWEEP_MIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:      mode_reg      <= cfg_data[MODE_W-1:0];
                CFG_UP_STEP:   up_step_reg   <= cfg_data[STEP_W-1:0];
                CFG_DOWN_STEP: down_step_reg <= cfg_data[STEP_W-1:0];
                CFG_SWEEP_MAX: sweep_max_reg <= cfg_data[RPM_W-1:0];
                CFG_SWEEP_MIN: sweep_min_reg <= cfg_data[RPM_W-1:0];
                default:       ;
            endcase
        end
    end

    // A restart reloads the start state ahead of the tick's own update.
    always_comb
    begin
        if (in_ch.restart)
        begin
            target_base   = '0;
            second_base   = 1'b0;
            finished_base = 1'b0;
            primed_base   = 1'b0;
            phase_base    = '0;
            offset_base   = OFFSET_LOW;
        end
        else
        begin
            target_base   = step_target_reg;
            second_base   = second_tick_reg;
            finished_base = finished_reg;
            primed_base   = primed_reg;
            phase_base    = sine_phase_reg;
            offset_base   = sine_offset_reg;
        end
    end

    // Tick update: one sweep step or one sine sample, depending on the mode.
    always_comb
    begin
        step_target_next = target_base;
        second_tick_next = second_base;
        finished_next    = finished_base;
        primed_next      = primed_base;
        sine_phase_next  = phase_base;
        sine_offset_next = offset_base;
        setpoint_next    = '0;
        done_next        = 1'b0;
        rpm              = '0;
        rpm_scaled       = '0;
        sine_sum         = '0;

        target_loaded  = primed_base ? target_base
                       : ((mode_reg == MODE_STEP_DOWN) ? TARGET_W'(sweep_max_reg)
                                                       : TARGET_W'(sweep_min_reg));
        phase_stride   = {1'b0, phase_base} + PHASE_INC;
        phase_inc      = {1'b0, phase_base} + (PHASE_W + 1)'(1);
        offset_stepped = offset_base + OFFSET_STEP;

        case (mode_reg)
            MODE_STEP_UP, MODE_UP_DOWN, MODE_STEP_DOWN:
            begin
                primed_next      = 1'b1;
                step_target_next = target_loaded;
                if (!finished_base)
                begin
                    if (!second_base)
                    begin
                        rpm              = target_loaded;
                        second_tick_next = 1'b1;
                    end
                    else
                    begin
                        second_tick_next = 1'b0;
                        if (mode_reg == MODE_STEP_DOWN)
                        begin
                            rpm = target_loaded;
                            if (TARGET_W'(down_step_reg) > target_loaded)
                            begin
                                step_target_next = '0;
                                finished_next    = 1'b1;
                            end
                            else
                            begin
                                step_target_next = target_loaded - TARGET_W'(down_step_reg);
                                finished_next    = step_target_next < TARGET_W'(sweep_min_reg);
                            end
                        end
                        else
                        begin
                            // The up-and-down sweep drops to zero on the second tick.
                            rpm = (mode_reg == MODE_STEP_UP) ? target_loaded : '0;
                            step_target_next = target_loaded + TARGET_W'(up_step_reg);
                            finished_next    = step_target_next > TARGET_W'(sweep_max_reg);
                        end
                        if (finished_next)
                        begin
                            rpm = '0;
                        end
                    end
                end
                rpm_scaled    = SUM_W'(rpm) << FRAC_BITS;
                setpoint_next = (rpm_scaled > SUM_W'(SETPOINT_MAX))
                              ? SETPOINT_W'(SETPOINT_MAX) : rpm_scaled[SETPOINT_W-1:0];
                done_next     = finished_next;
            end
            MODE_SINE, MODE_PERIODIC:
            begin
                if (mode_reg == MODE_SINE)
                begin
                    sine_sum        = (SUM_W'(SINE_CENTER) <<< FRAC_BITS) + SUM_W'(sample_a50);
                    sine_phase_next = (phase_stride >= PHASE_END)
                                    ? PHASE_W'(phase_stride - PHASE_END)
                                    : phase_stride[PHASE_W-1:0];
                end
                else
                begin
                    sine_sum = (SUM_W'(offset_base) <<< FRAC_BITS) + SUM_W'(sample_a100);
                    if (phase_inc >= PHASE_END)
                    begin
                        sine_phase_next  = '0;
                        sine_offset_next = (offset_stepped > OFFSET_HIGH) ? OFFSET_LOW
                                                                          : offset_stepped;
                    end
                    else
                    begin
                        sine_phase_next = phase_inc[PHASE_W-1:0];
                    end
                end
                if (sine_sum < 0)
                begin
                    setpoint_next = '0;
                end
                else if (sine_sum > SUM_W'(SETPOINT_MAX))
                begin
                    setpoint_next = SETPOINT_W'(SETPOINT_MAX);
                end
                else
                begin
                    setpoint_next = sine_sum[SETPOINT_W-1:0];
                end
            end
            default:
            begin
                // Unused mode codes give a zero result and only apply a restart.
                setpoint_next = '0;
            end
        endcase
    end

    // Profile state advances on every tick transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_target_reg <= '0;
            second_tick_reg <= 1'b0;
            finished_reg    <= 1'b0;
            primed_reg      <= 1'b0;
            sine_phase_reg  <= '0;
            sine_offset_reg <= OFFSET_LOW;
        end
        else if (tick_xfer)
        begin
            step_target_reg <= step_target_next;
            second_tick_reg <= second_tick_next;
            finished_reg    <= finished_next;
            primed_reg      <= primed_next;
            sine_phase_reg  <= sine_phase_next;
            sine_offset_reg <= sine_offset_next;
        end
    end

    // Output register: filled on a tick transfer, emptied on a result transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (tick_xfer)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_xfer)
        begin
            setpoint_reg <= setpoint_next;
            done_reg     <= done_next;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.setpoint   = setpoint_reg;
    assign out_ch.sweep_done = done_reg;

    // A finished sweep always reports a zero setpoint.
    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |-> setpoint_reg == '0)
        else $error("sweep done with nonzero setpoint");

    // The sine phase stays inside one period.
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, sine_phase_reg} < PHASE_END)
        else $error("sine phase out of range");

    // The periodic offset only takes its five steps.
    a_offset_set: assert property (@(posedge clk) disable iff (!rst_n)
        sine_offset_reg == 10'd350 || sine_offset_reg == 10'd400 ||
        sine_offset_reg == 10'd450 || sine_offset_reg == 10'd500 ||
        sine_offset_reg == 10'd550)
        else $error("sine offset off its sequence");

    // A sweep only finishes at the end of a tick pair.
    a_finish_pair: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |-> !second_tick_reg)
        else $error("finished sweep in mid pair");

    // The target is loaded only when the sweep is primed.
    a_unprimed_target: assert property (@(posedge clk) disable iff (!rst_n)
        !primed_reg |-> step_target_reg == '0)
        else $error("unprimed sweep holds a target");

    // A tick transfer always leaves a result waiting.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        tick_xfer |=> out_valid_reg)
        else $error("tick transfer without result");

endmodule
